// ----- design/fractional_rate_resampler_macros.svh -----
// assertion macros for the fractional rate resampler
// used by the checker module only
`ifndef FRACTIONAL_RATE_RESAMPLER_MACROS_SVH
`define FRACTIONAL_RATE_RESAMPLER_MACROS_SVH

// implication checked on every edge outside reset
`define FRR_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("frr check failed");

// next-cycle implication outside reset
`define FRR_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("frr check failed");

`endif

// ----- design/frr_pkg.sv -----
// shared types and constants for the fractional rate resampler
// no dependencies
package frr_pkg;

   localparam int PHASE_BITS = 26;
   localparam int RATIO_BITS = 24;
   localparam int COEF_BITS  = 16;
   localparam int CSR_BITS   = 24;
   localparam int CNT_BITS   = 9;

   localparam logic [2:0] CSR_DOWN_MODE = 3'd0;
   localparam logic [2:0] CSR_STEP      = 3'd1;
   localparam logic [2:0] CSR_B0        = 3'd2;
   localparam logic [2:0] CSR_B1        = 3'd3;
   localparam logic [2:0] CSR_B2        = 3'd4;
   localparam logic [2:0] CSR_A1        = 3'd5;
   localparam logic [2:0] CSR_A2        = 3'd6;

endpackage

// ----- design/frr_mac.sv -----
// biquad filter unit: one shared multiplier, one tap per cycle
// depends on frr_pkg
module frr_mac #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [SAMPLE_BITS-1:0]          x_in,
   input  logic signed [5*frr_pkg::COEF_BITS-1:0] coefs,
   output logic                                   done,
   output logic signed [SAMPLE_BITS-1:0]          y_out
);
   localparam int PROD_BITS = SAMPLE_BITS + frr_pkg::COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + 4;
   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [2:0] tap_ff, tap_in;
   logic       run_ff, run_in;
   logic       done_ff, done_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in, x2_ff, x2_in, y1_ff, y1_in, y2_ff, y2_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic signed [SAMPLE_BITS-1:0] op_s;
   logic signed [frr_pkg::COEF_BITS-1:0] op_c;
   logic signed [PROD_BITS-1:0]   prod;
   logic signed [ACC_BITS-1:0]    sum_full, shifted;

   // operand select per tap
   always_comb begin
      case (tap_ff)
         3'd0:    begin op_s = x_in;  op_c = coefs[0*16 +: 16]; end
         3'd1:    begin op_s = x1_ff; op_c = coefs[1*16 +: 16]; end
         3'd2:    begin op_s = x2_ff; op_c = coefs[2*16 +: 16]; end
         3'd3:    begin op_s = y1_ff; op_c = coefs[3*16 +: 16]; end
         default: begin op_s = y2_ff; op_c = coefs[4*16 +: 16]; end
      endcase
      prod = op_s * op_c;
      if (tap_ff >= 3'd3) sum_full = acc_ff - ACC_BITS'(prod);
      else                sum_full = acc_ff + ACC_BITS'(prod);
      shifted = sum_full >>> COEF_FRAC_BITS;
   end

   // sequencer
   always_comb begin
      tap_in = tap_ff; run_in = run_ff; acc_in = acc_ff; done_in = 1'b0;
      x1_in = x1_ff; x2_in = x2_ff; y1_in = y1_ff; y2_in = y2_ff; y_in = y_ff;
      if (start && !run_ff) begin
         run_in = 1'b1; tap_in = 3'd0; acc_in = '0;
      end else if (run_ff) begin
         acc_in = sum_full;
         tap_in = tap_ff + 3'd1;
         if (tap_ff == 3'd4) begin
            run_in = 1'b0; done_in = 1'b1;
            if (shifted > ACC_BITS'(SMAX))      y_in = SMAX;
            else if (shifted < ACC_BITS'(SMIN)) y_in = SMIN;
            else                                y_in = shifted[SAMPLE_BITS-1:0];
            x2_in = x1_ff; x1_in = x_in; y2_in = y1_ff; y1_in = y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0; run_ff <= 1'b0; done_ff <= 1'b0; acc_ff <= '0;
         x1_ff <= '0; x2_ff <= '0; y1_ff <= '0; y2_ff <= '0; y_ff <= '0;
      end else begin
         tap_ff <= tap_in; run_ff <= run_in; done_ff <= done_in; acc_ff <= acc_in;
         x1_ff <= x1_in; x2_ff <= x2_in; y1_ff <= y1_in; y2_ff <= y2_in; y_ff <= y_in;
      end
   end

   assign done  = done_ff;
   assign y_out = y_ff;
endmodule

// ----- design/frr_div.sv -----
// serial restoring divider: signed quotient from a magnitude division, one bit per cycle
// depends on nothing
module frr_div #(
   parameter int NUM_BITS = 25,
   parameter int DEN_BITS = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0]        den,
   output logic                       done,
   output logic signed [NUM_BITS-1:0] quot
);
   localparam int CB = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS:0]   r_ff, r_in;
   logic [DEN_BITS:0]   trial;
   logic [CB-1:0]       cnt_ff, cnt_in;
   logic                run_ff, run_in, neg_ff, neg_in, done_ff, done_in;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; run_in = run_ff;
      neg_in = neg_ff; done_in = 1'b0;
      trial = {r_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};
      if (start && !run_ff) begin
         neg_in = num[NUM_BITS-1];
         q_in   = num[NUM_BITS-1] ? NUM_BITS'(-num) : num;
         r_in   = '0; cnt_in = CB'(NUM_BITS); run_in = 1'b1;
      end else if (run_ff) begin
         // shift-subtract step
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) begin run_in = 1'b0; done_in = 1'b1; end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0; neg_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      end
      q_ff <= q_in; r_ff <= r_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? NUM_BITS'(-q_ff) : q_ff;
endmodule

// ----- design/fractional_rate_resampler.sv -----
// fractional rate resampler, zero-order hold up / biquad plus mean down
// channels: req_ in, rsp_ out, both valid/ready; csr_ write port.
// one input transfer is taken, then the block is busy until its burst of
// results is fully delivered. each input adds 1.0 to a Q10.16 phase;
// while the phase is not negative one result is sent and step_ratio is
// subtracted, at most MAX_BURST results per input, the last marked by
// rsp_burst_end.
// in down mode each input first passes the five-tap filter on the shared
// multiplier, and the first result of a burst with a non-zero count waits
// on the bit-serial divider. results stay in the output register while
// rsp_ready is low; nothing is lost and the sequencer waits.
// reset is synchronous: phase, hold, sum, count and filter history go to
// zero and the registers to their reset values.
// config must be written only while idle; the block itself does not enforce it.
module fractional_rate_resampler #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 14,
   parameter int MAX_BURST      = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                          rsp_burst_end,
   input  logic                          csr_write,
   input  logic [2:0]                    csr_index,
   input  logic [frr_pkg::CSR_BITS-1:0]  csr_data
);
   localparam int PB = frr_pkg::PHASE_BITS;
   localparam int NB = frr_pkg::CNT_BITS;
   localparam int SB = SAMPLE_BITS + NB;
   localparam int BB = $clog2(MAX_BURST + 1);
   localparam logic signed [PB-1:0] PONE = PB'(65536);
   localparam logic signed [PB-1:0] PMAX = {1'b0, {(PB-1){1'b1}}};

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FILT = 3'd1;
   localparam logic [2:0] ST_TEST = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] st_ff, st_in;
   logic       mode_ff;
   logic [frr_pkg::RATIO_BITS-1:0] step_ff;
   logic [5*frr_pkg::COEF_BITS-1:0] coef_ff;
   logic signed [PB-1:0] ph_ff, ph_in;
   logic signed [SAMPLE_BITS-1:0] held_ff, held_in, x_ff, x_in;
   logic signed [SB-1:0] sum_ff, sum_in;
   logic [NB-1:0] cnt_ff, cnt_in;
   logic [BB-1:0] n_ff, n_in;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;
   logic end_ff, end_in;
   logic signed [PB:0] ph_add;
   logic signed [PB-1:0] ph_sub;
   logic [BB-1:0] n_next;
   logic mac_start, mac_done, div_start, div_done;
   logic signed [SAMPLE_BITS-1:0] y_f;
   logic signed [SB-1:0] q;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; step_ff <= 24'd65536;
         coef_ff <= {16'd0, 16'd0, 16'd0, 16'd0, 16'd16384};
      end else if (csr_write) begin
         case (csr_index)
            frr_pkg::CSR_DOWN_MODE: mode_ff <= csr_data[0];
            frr_pkg::CSR_STEP:      step_ff <= csr_data;
            frr_pkg::CSR_B0:        coef_ff[0*16 +: 16] <= csr_data[15:0];
            frr_pkg::CSR_B1:        coef_ff[1*16 +: 16] <= csr_data[15:0];
            frr_pkg::CSR_B2:        coef_ff[2*16 +: 16] <= csr_data[15:0];
            frr_pkg::CSR_A1:        coef_ff[3*16 +: 16] <= csr_data[15:0];
            frr_pkg::CSR_A2:        coef_ff[4*16 +: 16] <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   frr_mac #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
      .clock(clock), .reset(reset), .start(mac_start), .x_in(x_ff),
      .coefs(coef_ff), .done(mac_done), .y_out(y_f));

   frr_div #(.NUM_BITS(SB), .DEN_BITS(NB)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(sum_ff),
      .den(cnt_ff), .done(div_done), .quot(q));

   assign ph_add = {ph_ff[PB-1], ph_ff} + {PONE[PB-1], PONE};
   assign ph_sub = ph_ff - PB'(step_ff);
   assign n_next = n_ff + BB'(1);

   // sequencer
   always_comb begin
      st_in = st_ff; ph_in = ph_ff; held_in = held_ff; x_in = x_ff;
      sum_in = sum_ff; cnt_in = cnt_ff; n_in = n_ff; out_in = out_ff;
      end_in = end_ff;
      mac_start = 1'b0; div_start = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in = req_in_sample; n_in = '0;
               ph_in = (ph_add > $signed({1'b0, PMAX})) ? PMAX : ph_add[PB-1:0];
               if (mode_ff) st_in = ST_FILT;
               else begin held_in = req_in_sample; st_in = ST_TEST; end
            end
         end
         ST_FILT: begin
            // one filter pass per input, no restart on the done cycle
            mac_start = !mac_done;
            if (mac_done) begin
               held_in = y_f;
               if (cnt_ff != {NB{1'b1}}) begin
                  sum_in = sum_ff + SB'(y_f); cnt_in = cnt_ff + NB'(1);
               end
               st_in = ST_TEST;
            end
         end
         ST_TEST: begin
            // emit one result or finish
            if (!ph_ff[PB-1] && (n_ff != BB'(MAX_BURST))) begin
               ph_in = ph_sub; n_in = n_next;
               end_in = ph_sub[PB-1] || (n_next == BB'(MAX_BURST));
               if (!mode_ff)               begin out_in = held_ff; st_in = ST_OUT; end
               else if (cnt_ff == '0)     begin out_in = '0; st_in = ST_OUT; end
               else begin div_start = 1'b1; st_in = ST_DIV; end
            end else st_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) begin
               out_in = q[SAMPLE_BITS-1:0]; sum_in = '0; cnt_in = '0; st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) st_in = end_ff ? ST_IDLE : ST_TEST;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ph_ff <= '0; held_ff <= '0; sum_ff <= '0; cnt_ff <= '0;
         n_ff <= '0; end_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; held_ff <= held_in; sum_ff <= sum_in;
         cnt_ff <= cnt_in; n_ff <= n_in; end_ff <= end_in;
      end
      x_ff <= x_in; out_ff <= out_in;
   end

   assign req_ready      = (st_ff == ST_IDLE);
   assign rsp_valid      = (st_ff == ST_OUT);
   assign rsp_out_sample = out_ff;
   assign rsp_burst_end  = end_ff;
endmodule

// ----- design/frr_checker.sv -----
// port-level checks for the fractional rate resampler
// depends on fractional_rate_resampler_macros.svh
`include "fractional_rate_resampler_macros.svh"
module frr_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_out_sample,
   input logic                   rsp_burst_end
);
   // no input is taken while a result waits
   `FRR_ASSERT_IMP(a_excl, clock, reset, rsp_valid, !req_ready)
   // a stalled result holds its value
   `FRR_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_sample) && $stable(rsp_burst_end))
   // after the last result of a burst the block is ready again
   `FRR_ASSERT_NXT(a_done, clock, reset, rsp_valid && rsp_ready && rsp_burst_end,
      req_ready)
   // a transfer on the input makes the block busy
   `FRR_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind fractional_rate_resampler frr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_frr_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_sample(rsp_out_sample),
   .rsp_burst_end(rsp_burst_end));

// ----- tb/sv/fractional_rate_resampler_test.sv -----
// testbench for fractional_rate_resampler: random and directed samples under random idling
// depends on frr_pkg and the fractional_rate_resampler rtl
module fractional_rate_resampler_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] sample;
      logic        last;
   } burst_item_type;

   // predicts each burst of results and checks what the block sends
   class resample_scoreboard;
      bit          down;
      longint      ratio, b0, b1, b2, a1, a2;
      longint      phase, held, sum, cnt, x1, x2, y1, y2;
      burst_item_type pending[$];
      int          errors;

      function void set_config(bit m, longint r, longint c0, longint c1, longint c2,
                               longint d1, longint d2);
         down = m; ratio = r; b0 = c0; b1 = c1; b2 = c2; a1 = d1; a2 = d2;
      endfunction

      function void note_input(logic signed [15:0] s);
         longint x, acc, y, v;
         int n;
         burst_item_type it;
         x = s;
         n = 0;
         if (down) begin
            acc = b0 * x + b1 * x1 + b2 * x2 - a1 * y1 - a2 * y2;
            y = acc >>> 14;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            x2 = x1; x1 = x; y2 = y1; y1 = y;
            // sum saturates its count and stops adding
            if (cnt < 511) begin
               sum += y;
               cnt++;
            end
            held = y;
         end else begin
            held = x;
         end
         phase += 65536;
         if (phase > 33554431) phase = 33554431;
         // one result per non-negative phase, capped per input
         while (phase >= 0 && n < 64) begin
            phase -= ratio;
            if (down) begin
               if (cnt == 0) v = 0;
               else begin
                  v = sum / cnt;
                  sum = 0;
                  cnt = 0;
               end
            end else begin
               v = held;
            end
            it.sample = v[15:0];
            it.last = 1'b0;
            pending.push_back(it);
            n++;
         end
         if (n > 0) pending[pending.size()-1].last = 1'b1;
      endfunction

      function void check_result(logic [15:0] smp, logic last);
         burst_item_type want;
         if (pending.size() == 0) begin
            $error("unexpected result transfer: out_sample %0h burst_end %0b", smp, last);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (smp !== want.sample) begin
            $error("out_sample expected %0h actual %0h", want.sample, smp);
            errors++;
         end
         if (last !== want.last) begin
            $error("burst_end expected %0b actual %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [15:0]   req_in_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [15:0]   rsp_out_sample;
   logic                 rsp_burst_end;
   logic                 csr_write = 1'b0;
   logic [2:0]           csr_index = frr_pkg::CSR_DOWN_MODE;
   logic [frr_pkg::CSR_BITS-1:0] csr_data = '0;

   resample_scoreboard sb = new();
   int send_pct = 38;
   int recv_pct = 75;
   int items_sent = 0;

   fractional_rate_resampler DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_out_sample, rsp_burst_end);
         rsp_ready <= ($urandom_range(99) >= recv_pct);
      end
   end

   // idling regime follows the progress of the run
   always @(posedge clock) begin
      if (items_sent < 80) begin
         send_pct <= 38; recv_pct <= 75;
      end else if (items_sent < 160) begin
         send_pct <= 75; recv_pct <= 38;
      end else begin
         send_pct <= 0; recv_pct <= 0;
      end
   end

   task automatic send_sample(logic signed [15:0] s);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_sample <= s;
      do @(posedge clock); while (!req_ready);
      sb.note_input(s);
      items_sent++;
   endtask

   // sender pauses until every expected result has come, then lets the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [frr_pkg::CSR_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   task automatic apply_config(bit m, logic [23:0] r, logic signed [15:0] c0,
                               logic signed [15:0] c1, logic signed [15:0] c2,
                               logic signed [15:0] d1, logic signed [15:0] d2);
      write_reg(frr_pkg::CSR_DOWN_MODE, {23'd0, m});
      write_reg(frr_pkg::CSR_STEP, r);
      write_reg(frr_pkg::CSR_B0, {{8{c0[15]}}, c0});
      write_reg(frr_pkg::CSR_B1, {{8{c1[15]}}, c1});
      write_reg(frr_pkg::CSR_B2, {{8{c2[15]}}, c2});
      write_reg(frr_pkg::CSR_A1, {{8{d1[15]}}, d1});
      write_reg(frr_pkg::CSR_A2, {{8{d2[15]}}, d2});
      csr_write <= 1'b0;
      sb.set_config(m, r, c0, c1, c2, d1, d2);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return $urandom_range(3) - 2;
         default: return $urandom_range(65535);
      endcase
   endfunction

   initial begin
      logic [15:0] corner[8] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
                                 16'hffff, 16'h5555, 16'haaaa, 16'h1234};
      logic [23:0] r;
      sb.set_config(1'b0, 65536, 16384, 0, 0, 0, 0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one-to-one hold
      foreach (corner[i]) send_sample(corner[i]);
      drain();
      // down mode, extreme coefficients drive the filter into saturation
      apply_config(1'b1, 24'd196608, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      foreach (corner[i]) send_sample(corner[i]);
      drain();
      // smallest ratio hits the burst cap; down mode gives the mean then zeros
      apply_config(1'b1, 24'd1024, 16384, 0, 0, 0, 0);
      send_sample(16'h4000);
      send_sample(16'hc000);
      drain();
      apply_config(1'b0, 24'd1024, 16384, 0, 0, 0, 0);
      send_sample(16'h7fff);
      send_sample(16'h8000);
      drain();
      // largest ratio: one result then a long run of none
      apply_config(1'b0, 24'hffffff, 0, 0, 0, 0, 0);
      repeat (4) send_sample($urandom_range(65535));
      drain();

      // random phases, each with fresh settings
      while (items_sent < 230) begin
         case ($urandom_range(3))
            0: r = 65536;
            1: r = $urandom_range(16384, 262144);
            2: r = $urandom_range(1024, 8192);
            default: r = $urandom_range(262144, 16777215);
         endcase
         if ($urandom_range(1))
            apply_config($urandom_range(1), r, $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
         else
            apply_config($urandom_range(1), r, 16'sd4096, 16'sd8192, 16'sd4096,
                         -16'sd8192, 16'sd4096);
         repeat ($urandom_range(15, 30)) send_sample(pick_sample());
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

// ----- fractional_rate_resampler.f -----
+incdir+design
design/frr_pkg.sv
design/frr_mac.sv
design/frr_div.sv
design/fractional_rate_resampler.sv
design/frr_checker.sv
tb/sv/fractional_rate_resampler_test.sv
